FILE: hw/rtl/hfr_pkg.sv
`default_nettype none

package hfr_pkg;

    // Framing constants
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'h0000;
    localparam int          SEQ_W     = 3;
    localparam logic [7:0]  CNT_MAX   = 8'hFF;

    // Configuration register indexes
    localparam int                CFG_IW          = 2;
    localparam logic [CFG_IW-1:0] REG_SERVER_ADDR = 2'd0;
    localparam logic [CFG_IW-1:0] REG_CLIENT_ADDR = 2'd1;
    localparam logic [CFG_IW-1:0] REG_MAX_INFO    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_SERVER_ADDR = 8'd1;
    localparam logic [7:0] RST_CLIENT_ADDR = 8'd2;
    localparam logic [7:0] RST_MAX_INFO    = 8'd64;

    // Queue between front and back
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One classified item: payload byte plus everything the back end needs
    typedef struct packed {
        logic [7:0] data;
        logic       hdr;     // opens a frame: flag, address, control go first
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic       close;   // frame closes after this byte: FCS follows
    } q_entry_t;

    // Next byte to emit for the entry at the queue head
    typedef enum logic [2:0] {
        PH_START,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_DATA,
        PH_FCS_LO,
        PH_FCS_HI
    } phase_t;

    // CRC-16, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hfr_front.sv
`default_nettype none

module hfr_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    input  wire logic [hfr_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [7:0]                 cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 in_byte,
    input  wire logic                       in_last,
    input  wire logic                       in_dest,
    input  wire logic                       q_full,
    output logic                            q_push,
    output hfr_pkg::q_entry_t               q_entry
);
    import hfr_pkg::*;

    logic [7:0]       server_addr_reg;
    logic [7:0]       client_addr_reg;
    logic [7:0]       max_info_reg;
    logic [SEQ_W-1:0] seq_reg [2];
    logic             inside_reg;
    logic             inside_next;
    logic [7:0]       count_reg;
    logic [7:0]       count_next;
    logic             dest_reg;
    logic             dest_next;

    logic             dest;
    logic [7:0]       limit;
    logic [7:0]       count_base;
    logic [7:0]       count_inc;
    logic             close;
    logic             accept;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_addr_reg <= RST_SERVER_ADDR;
            client_addr_reg <= RST_CLIENT_ADDR;
            max_info_reg    <= RST_MAX_INFO;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SERVER_ADDR: server_addr_reg <= cfg_data;
                REG_CLIENT_ADDR: client_addr_reg <= cfg_data;
                REG_MAX_INFO:    max_info_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    // Classify the item against the open frame
    always_comb
    begin
        limit      = (max_info_reg == 8'd0) ? 8'd1 : max_info_reg;
        dest       = inside_reg ? dest_reg : in_dest;
        count_base = inside_reg ? count_reg : 8'd0;
        count_inc  = (count_base == CNT_MAX) ? CNT_MAX : count_base + 8'd1;
        close      = in_last || (count_inc >= limit);

        q_entry.data  = in_byte;
        q_entry.hdr   = !inside_reg;
        q_entry.addr  = dest ? server_addr_reg : client_addr_reg;
        q_entry.ctrl  = {3'b000, 1'b1, seq_reg[dest], 1'b0};
        q_entry.close = close;

        inside_next = inside_reg;
        count_next  = count_reg;
        dest_next   = dest_reg;
        if (accept)
        begin
            inside_next = !close;
            count_next  = close ? 8'd0 : count_inc;
            dest_next   = dest;
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            count_reg  <= 8'd0;
            dest_reg   <= 1'b0;
            seq_reg[0] <= '0;
            seq_reg[1] <= '0;
        end
        else
        begin
            inside_reg <= inside_next;
            count_reg  <= count_next;
            dest_reg   <= dest_next;
            if (accept && !inside_reg)
                seq_reg[dest] <= seq_reg[dest] + SEQ_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hfr_fifo.sv
`default_nettype none

module hfr_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire hfr_pkg::q_entry_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output hfr_pkg::q_entry_t      head
);
    import hfr_pkg::*;

    q_entry_t        mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic [Q_AW:0]   count_next;

    assign full       = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (Q_AW+1)'(1);
            2'b01:   count_next = count_reg - (Q_AW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hfr_back.sv
`default_nettype none

module hfr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire hfr_pkg::q_entry_t q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_frame_end,
    output logic                   out_run_last
);
    import hfr_pkg::*;

    phase_t      ph_reg;
    phase_t      ph_next;
    phase_t      eff;
    phase_t      follow;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  byte_reg;
    logic        fe_reg;
    logic        rl_reg;

    logic        load;
    logic        entry_done;
    logic [7:0]  byte_sel;
    logic        fe_sel;
    logic        rl_sel;
    logic [15:0] crc_in;

    assign load = q_valid && (!out_valid_reg || out_ready);

    // Byte sequencer over the head entry
    always_comb
    begin
        eff = ph_reg;
        if (ph_reg == PH_START)
            eff = q_head.hdr ? PH_FLAG : PH_DATA;

        byte_sel   = q_head.data;
        fe_sel     = 1'b0;
        rl_sel     = 1'b0;
        entry_done = 1'b0;
        follow     = PH_START;
        case (eff)
            PH_FLAG:
            begin
                byte_sel = FLAG_BYTE;
                follow   = PH_ADDR;
            end
            PH_ADDR:
            begin
                byte_sel = q_head.addr;
                follow   = PH_CTRL;
            end
            PH_CTRL:
            begin
                byte_sel = q_head.ctrl;
                follow   = PH_DATA;
            end
            PH_DATA:
            begin
                byte_sel = q_head.data;
                if (q_head.close)
                    follow = PH_FCS_LO;
                else
                begin
                    rl_sel     = 1'b1;
                    entry_done = 1'b1;
                end
            end
            PH_FCS_LO:
            begin
                byte_sel = crc_reg[7:0];
                follow   = PH_FCS_HI;
            end
            PH_FCS_HI:
            begin
                byte_sel   = crc_reg[15:8];
                fe_sel     = 1'b1;
                rl_sel     = 1'b1;
                entry_done = 1'b1;
            end
            default:
            begin
                follow = PH_START;
            end
        endcase

        q_pop   = load && entry_done;
        ph_next = ph_reg;
        if (load)
            ph_next = entry_done ? PH_START : follow;

        // CRC restarts on the flag, holds while the FCS goes out
        crc_in   = (eff == PH_FLAG) ? CRC_INIT : crc_reg;
        crc_next = crc_reg;
        if (load && eff != PH_FCS_LO && eff != PH_FCS_HI)
            crc_next = crc16_byte(crc_in, byte_sel);

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= PH_START;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ph_reg        <= ph_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_sel;
            fe_reg   <= fe_sel;
            rl_reg   <= rl_sel;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = byte_reg;
    assign out_frame_end = fe_reg;
    assign out_run_last  = rl_reg;

    // A frame close is always the last byte of its item
    a_fe_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fe_reg |-> rl_reg)
        else $error("frame end without run end");

    // Low FCS byte is always followed by the high one
    a_fcs_order: assert property (@(posedge clk) disable iff (!rst_n)
        load && eff == PH_FCS_LO |=> ph_reg == PH_FCS_HI)
        else $error("FCS sequence broken");

    // Mid-sequence the entry must still sit at the queue head
    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg != PH_START |-> q_valid)
        else $error("queue head lost mid-sequence");

endmodule

`default_nettype wire

FILE: hw/rtl/hdlc_iframe_tx_framer_top.sv
// HDLC I-frame transmit framer with CRC-16 FCS.
// With the queue empty, an item goes into the queue, then its first byte into the output register.
// Throughput: one input item per cycle while the 8-entry queue has room; output runs
// one byte per cycle while the receiver is ready. An item puts out its data byte, plus flag,
// address and control when it opens a frame and two FCS bytes when it closes one (up to 6 bytes).
// Reset: config to server 1, client 2, max 64; send numbers zero, no frame open, queue empty.
`default_nettype none

module hdlc_iframe_tx_framer_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [hfr_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [7:0]                 cfg_data,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] payload_byte
    input  wire logic                       s_tlast,   // message_end
    input  wire logic                       s_tuser,   // [0] to_server
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] out_byte
    output logic                            m_tlast,   // frame_end
    output logic                            m_tuser    // [0] run_last
);
    import hfr_pkg::*;

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_in;
    q_entry_t q_head;

    assign cfg_ready = 1'b1;

    hfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .in_dest   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    hfr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    hfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (m_tdata),
        .out_frame_end (m_tlast),
        .out_run_last  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;

    import hfr_pkg::*;

    // Index with no register behind it; writes to it are dropped
    localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       msg_end;
        logic       to_srv;
    } tx_item_t;

    typedef struct packed {
        logic [7:0] octet;
        logic       fend;
        logic       rlast;
    } out_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [7:0]        cfg_data = '0;

    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic       s_tlast = 1'b0;
    logic       s_tuser = 1'b0;

    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    // Items waiting to be sent, bytes waiting to come out
    tx_item_t pend_items[$];
    out_rec_t exp_bytes[$];
    int n_queued = 0;
    int n_acc = 0;
    int err_cnt = 0;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    // Long receiver hold-off, requested once
    logic stress_req = 1'b0;
    logic stress_done = 1'b0;
    int   hold_left = 0;

    int idle_cyc = 0;

    // Framer state kept by the testbench
    logic [7:0]  srv_addr = RST_SERVER_ADDR;
    logic [7:0]  cli_addr = RST_CLIENT_ADDR;
    logic [7:0]  max_pay = RST_MAX_INFO;
    logic [2:0]  seq_no[2] = '{3'd0, 3'd0};
    logic [15:0] fcs_acc = 16'h0000;
    logic        in_frame = 1'b0;
    logic [7:0]  pay_cnt = 8'd0;
    logic        frame_dest = 1'b0;

    hdlc_iframe_tx_framer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // CRC-16 0x1021, MSB first, one bit at a time
    function automatic logic [15:0] fcs_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Bytes put on the line for one accepted payload item
    function automatic void frame_bytes(input tx_item_t it);
        out_rec_t   r[6];
        int         n;
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] lim;
        n = 0;
        lim = (max_pay == 8'd0) ? 8'd1 : max_pay;
        if (!in_frame)
        begin
            frame_dest = it.to_srv;
            addr = frame_dest ? srv_addr : cli_addr;
            // N(R)=0, P/F=1, N(S), I-frame bit 0
            ctrl = {3'b000, 1'b1, seq_no[frame_dest], 1'b0};
            seq_no[frame_dest] = seq_no[frame_dest] + 3'd1;
            fcs_acc = fcs_next(fcs_next(fcs_next(CRC_INIT, FLAG_BYTE), addr), ctrl);
            r[0] = '{FLAG_BYTE, 1'b0, 1'b0};
            r[1] = '{addr, 1'b0, 1'b0};
            r[2] = '{ctrl, 1'b0, 1'b0};
            n = 3;
            pay_cnt = 8'd0;
            in_frame = 1'b1;
        end
        fcs_acc = fcs_next(fcs_acc, it.data);
        r[n] = '{it.data, 1'b0, 1'b0};
        n++;
        if (pay_cnt != CNT_MAX)
            pay_cnt = pay_cnt + 8'd1;
        // close on message end or size reached; FCS low byte first
        if (it.msg_end || pay_cnt >= lim)
        begin
            r[n] = '{fcs_acc[7:0], 1'b0, 1'b0};
            r[n+1] = '{fcs_acc[15:8], 1'b1, 1'b0};
            n += 2;
            in_frame = 1'b0;
            pay_cnt = 8'd0;
            fcs_acc = CRC_INIT;
        end
        r[n-1].rlast = 1'b1;
        for (int k = 0; k < n; k++)
            exp_bytes.push_back(r[k]);
    endfunction

    task automatic report_mismatch(input string what, input int expv, input int actv);
        if (err_cnt < 10)
            $display("mismatch %s: expected %0h got %0h", what, expv, actv);
        err_cnt++;
    endtask

    // Payload driver
    always @(posedge clk or negedge rst_n)
    begin
        tx_item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                frame_bytes('{s_tdata, s_tlast, s_tuser});
                n_acc++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pend_items.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt = pend_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.msg_end;
                    s_tuser  <= nxt.to_srv;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long hold-off counter
    always @(posedge clk)
    begin
        if (stress_req && !stress_done)
        begin
            hold_left <= HOLD_CYCLES;
            stress_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end

    // Output monitor
    always @(posedge clk)
    begin
        out_rec_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exp_bytes.size() == 0)
                report_mismatch("byte with none expected", 0, m_tdata);
            else
            begin
                e = exp_bytes.pop_front();
                if (m_tdata !== e.octet)
                    report_mismatch("out_byte", e.octet, m_tdata);
                if (m_tlast !== e.fend)
                    report_mismatch("frame_end", e.fend, m_tlast);
                if (m_tuser !== e.rlast)
                    report_mismatch("run_last", e.rlast, m_tuser);
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SERVER_ADDR: srv_addr = val;
            REG_CLIENT_ADDR: cli_addr = val;
            REG_MAX_INFO:    max_pay = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic push_item(input logic [7:0] d, input logic e, input logic srv);
        pend_items.push_back('{d, e, srv});
        n_queued++;
    endtask

    task automatic push_msg(input int len);
        for (int i = 0; i < len; i++)
            push_item(8'($urandom_range(255)), i == len - 1, 1'($urandom_range(1)));
    endtask

    // Wait until every item is in and every byte is out
    task automatic wait_idle();
        while (n_acc != n_queued || exp_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_setup();
        int pick;
        pick = $urandom_range(9);
        cfg_write(REG_SERVER_ADDR, 8'($urandom_range(255)));
        cfg_write(REG_CLIENT_ADDR, 8'($urandom_range(255)));
        if (pick == 0)
            cfg_write(REG_MAX_INFO, 8'd0);
        else if (pick == 1)
            cfg_write(REG_MAX_INFO, 8'd255);
        else
            cfg_write(REG_MAX_INFO, 8'($urandom_range(1, 8)));
    endtask

    initial
    begin
        int cnt;
        int len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one-byte messages, destination flipped mid-frame
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'h5A, 1'b0, 1'b1);
        push_item(8'h81, 1'b1, 1'b0);
        wait_idle();

        // Address extremes, zero frame size, unused index
        cfg_write(REG_SERVER_ADDR, 8'hFF);
        cfg_write(REG_CLIENT_ADDR, 8'h00);
        cfg_write(REG_MAX_INFO, 8'd0);
        cfg_write(REG_SPARE, 8'h55);
        push_item(8'h7E, 1'b0, 1'b1);
        push_item(8'h3C, 1'b0, 1'b0);
        wait_idle();

        // Message end on a size boundary, then a fresh frame
        cfg_write(REG_MAX_INFO, 8'd2);
        push_item(8'h01, 1'b0, 1'b0);
        push_item(8'h02, 1'b0, 1'b0);
        push_item(8'h03, 1'b0, 1'b1);
        push_item(8'h04, 1'b1, 1'b1);
        push_item(8'h05, 1'b0, 1'b1);
        push_item(8'h06, 1'b1, 1'b0);
        wait_idle();

        // Size lowered below the count of an open frame
        cfg_write(REG_MAX_INFO, 8'd4);
        push_item(8'h11, 1'b0, 1'b1);
        push_item(8'h22, 1'b0, 1'b0);
        push_item(8'h33, 1'b0, 1'b1);
        wait_idle();
        cfg_write(REG_MAX_INFO, 8'd2);
        push_item(8'h44, 1'b0, 1'b0);
        wait_idle();

        // Send number wraps past 7
        cfg_write(REG_MAX_INFO, 8'd1);
        for (int i = 0; i < 9; i++)
            push_item(8'($urandom_range(255)), 1'b0, 1'b1);
        wait_idle();

        // Largest frame size, message ends well short of it
        cfg_write(REG_MAX_INFO, 8'd255);
        push_msg(12);
        wait_idle();

        // Random messages under each idling pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct = 88;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 88;
                end
                default:
                begin
                    tx_idle_pct = 36;
                    rx_stall_pct = 36;
                end
            endcase
            for (int sub = 0; sub < 2; sub++)
            begin
                random_setup();
                if (ph == 0 && sub == 0)
                    stress_req = 1'b1;
                cnt = 0;
                while (cnt < 10)
                begin
                    len = $urandom_range(1, 12);
                    push_msg(len);
                    cnt += len;
                end
                wait_idle();
            end
        end

        wait_idle();
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
